// ----- rtl/ascii_digits_to_packed_bcd_unit_macros.svh -----
// Assertion macros shared by the packed BCD encoder RTL.
// Needs a clock named clk and an active-high reset named rst in the using scope.
`ifndef ASCII_DIGITS_TO_PACKED_BCD_UNIT_MACROS_SVH
`define ASCII_DIGITS_TO_PACKED_BCD_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ADPB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adpb: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ADPB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adpb: next-cycle check failed");

`endif

// ----- rtl/adpb_pkg.sv -----
// Types and constants for the ASCII digit to packed BCD encoder.
// No dependencies; used by the top level and the testbench.
package adpb_pkg;

  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_NINE    = 8'h39;
  localparam logic [3:0] SIGN_POSITIVE = 4'hF;
  localparam logic [3:0] SIGN_NEGATIVE = 4'hB;
  localparam logic [3:0] NIBBLE_ZERO   = 4'h0;
  localparam logic [7:0] COUNT_MAX     = 8'hFF;

  localparam int unsigned CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OUTPUT_FORMAT       = 2'd0,
    REG_START_IN_LOW_NIBBLE = 2'd1,
    REG_PAD_ODD_LENGTH      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       first_char;
    logic       last_char;
    logic       odd_length;
    logic       negative;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic [7:0] nybble_count;
    logic       error;
    logic       string_end;
  } out_item_t;

endpackage

// ----- rtl/adpb_stream_if.sv -----
// Valid/ready stream channel carrying one payload struct per item.
// Payload types come from adpb_pkg.
interface adpb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/ascii_digits_to_packed_bcd_unit.sv -----
// Top level of the ASCII digit to packed BCD encoder.
// Depends on adpb_pkg, adpb_stream_if and the macros header.
//
//   channel   direction  payload      handshake
//   in_ch     sink       in_item_t    valid/ready, one character per item
//   out_ch    source     out_item_t   valid/ready, at most one byte per item
//   cfg_*     write      1-bit value  cfg_write, cfg_index, cfg_data
//
// Each item is held in the input register and any byte it makes in the result
// register; the block sustains one item per clock while out_ch does not stall,
// set by the single nibble merge between the two registers. rst is synchronous
// and active high; it clears both valid flags, the configuration and the string
// state. A stall on out_ch holds the result register and, behind it, the input
// register; in_ch stays ready whenever the input register empties in the same cycle.
`include "ascii_digits_to_packed_bcd_unit_macros.svh"

module ascii_digits_to_packed_bcd_unit
  import adpb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic                   cfg_data,
  adpb_stream_if.sink            in_ch,
  adpb_stream_if.source          out_ch
);

  // Configuration registers; the user writes them only while the block is idle, which the block does not enforce.
  logic output_format;
  logic start_in_low_nibble;
  logic pad_odd_length;

  // Input register.
  logic     item_valid;
  in_item_t item;

  // String state carried from one character to the next.
  logic [3:0] held_high_nibble;
  logic       low_nibble_next;
  logic [7:0] converted_count;
  logic       skip_rest;

  logic [3:0] held_high_nibble_next;
  logic       low_nibble_next_next;
  logic [7:0] converted_count_next;
  logic       skip_rest_next;

  // Result register.
  logic      result_valid;
  out_item_t result;

  logic      result_emit;
  out_item_t result_next;
  logic      advance;

  // The input register hands its item on whenever the result register is
  // empty or is being emptied in this cycle.
  assign advance      = item_valid && (!result_valid || out_ch.ready);
  assign in_ch.ready  = !item_valid || advance;
  assign out_ch.valid = result_valid;
  assign out_ch.payload = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_format       <= 1'b0;
      start_in_low_nibble <= 1'b0;
      pad_odd_length      <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_OUTPUT_FORMAT:       output_format       <= cfg_data;
        REG_START_IN_LOW_NIBBLE: start_in_low_nibble <= cfg_data;
        REG_PAD_ODD_LENGTH:      pad_odd_length      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Merge of one character into the string state. A first character resets
  // the state and sets the starting nibble phase before the character itself
  // is looked at.
  always_comb begin
    logic [3:0] held_base;
    logic       phase_base;
    logic [7:0] count_base;
    logic       skip_base;
    logic [7:0] count_bumped;
    logic [3:0] digit;
    logic [3:0] sign_nibble;
    logic       is_digit;

    if (item.first_char) begin
      held_base  = NIBBLE_ZERO;
      skip_base  = 1'b0;
      if (output_format) begin
        phase_base = !item.odd_length;
        count_base = '0;
      end else if (start_in_low_nibble) begin
        phase_base = 1'b1;
        count_base = '0;
      end else begin
        // The plain-mode leading pad nibble is counted.
        phase_base = pad_odd_length && item.odd_length;
        count_base = {7'd0, phase_base};
      end
    end else begin
      held_base  = held_high_nibble;
      phase_base = low_nibble_next;
      count_base = converted_count;
      skip_base  = skip_rest;
    end

    count_bumped = (count_base != COUNT_MAX) ? count_base + 8'd1 : count_base;
    digit        = item.char_code[3:0] - ASCII_ZERO[3:0];
    is_digit     = (item.char_code >= ASCII_ZERO) && (item.char_code <= ASCII_NINE);
    sign_nibble  = output_format ? (item.negative ? SIGN_NEGATIVE : SIGN_POSITIVE)
                                 : NIBBLE_ZERO;

    held_high_nibble_next = held_base;
    low_nibble_next_next  = phase_base;
    converted_count_next  = count_base;
    skip_rest_next        = skip_base;
    result_emit           = 1'b0;
    result_next           = '0;

    if (skip_base) begin
      // Rest of an aborted string: swallowed without a result.
    end else if (!is_digit) begin
      result_emit              = 1'b1;
      result_next.packed_byte  = '0;
      result_next.nybble_count = count_base;
      result_next.error        = 1'b1;
      result_next.string_end   = 1'b1;
      skip_rest_next           = 1'b1;
    end else if (!phase_base) begin
      held_high_nibble_next = digit;
      low_nibble_next_next  = 1'b1;
      converted_count_next  = count_bumped;
      if (item.last_char) begin
        // Odd trailing digit: plain mode pads with zero, packed mode adds the sign.
        result_emit              = 1'b1;
        result_next.packed_byte  = {digit, sign_nibble};
        result_next.nybble_count = count_bumped;
        result_next.string_end   = 1'b1;
      end
    end else begin
      result_emit              = 1'b1;
      result_next.packed_byte  = {held_base, digit};
      result_next.nybble_count = count_bumped;
      result_next.string_end   = item.last_char;
      held_high_nibble_next    = NIBBLE_ZERO;
      low_nibble_next_next     = 1'b0;
      converted_count_next     = count_bumped;
    end

    // The end of any string returns the block to idle.
    if (item.last_char) begin
      held_high_nibble_next = NIBBLE_ZERO;
      low_nibble_next_next  = 1'b0;
      converted_count_next  = '0;
      skip_rest_next        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid       <= 1'b0;
      result_valid     <= 1'b0;
      held_high_nibble <= NIBBLE_ZERO;
      low_nibble_next  <= 1'b0;
      converted_count  <= '0;
      skip_rest        <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        item_valid <= in_ch.valid;
      end
      if (advance) begin
        held_high_nibble <= held_high_nibble_next;
        low_nibble_next  <= low_nibble_next_next;
        converted_count  <= converted_count_next;
        skip_rest        <= skip_rest_next;
        result_valid     <= result_emit;
      end else if (out_ch.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item <= in_ch.payload;
    end
    if (advance && result_emit) begin
      result <= result_next;
    end
  end

  // An error result always closes its string and carries a zero byte.
  `ADPB_ASSERT_SAME(a_error_closes, result_valid && result.error,
    result.string_end && (result.packed_byte == 8'h00))

  // A string's last character leaves the block idle.
  `ADPB_ASSERT_NEXT(a_idle_after_last, advance && item.last_char,
    !low_nibble_next && (converted_count == 8'h00) && !skip_rest)

  // An empty input register never blocks the input channel.
  `ADPB_ASSERT_SAME(a_ready_when_empty, !item_valid, in_ch.ready)

  // A good result has a decimal high nibble and a digit, zero or sign low nibble.
  `ADPB_ASSERT_SAME(a_result_nibbles, result_valid && !result.error,
    (result.packed_byte[7:4] <= 4'd9) && ((result.packed_byte[3:0] <= 4'd9) ||
    (result.packed_byte[3:0] == SIGN_POSITIVE) || (result.packed_byte[3:0] == SIGN_NEGATIVE)))

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for ascii_digits_to_packed_bcd_unit: drives digit strings and checks
// every packed byte against a predictor kept in step with the accepted characters.
// Depends on adpb_pkg, adpb_stream_if and the RTL of the block.
module tb
  import adpb_pkg::*;
();

  // Predicts the packed bytes of the encoder and checks each result in order.
  // The string state moves with every accepted character. The configuration
  // is updated when a register write has taken effect.
  class packed_bcd_predictor;
    logic       comp3_mode;
    logic       low_start;
    logic       pad_odd;
    logic [3:0] held_digit;
    logic       low_next;
    logic [7:0] nibble_count;
    logic       aborted;
    out_item_t  expected_bytes[$];
    int         mismatches;

    function new();
      comp3_mode = 1'b0;
      low_start  = 1'b0;
      pad_odd    = 1'b0;
      mismatches = 0;
      drop_string();
    endfunction

    function void drop_string();
      held_digit   = NIBBLE_ZERO;
      low_next     = 1'b0;
      nibble_count = '0;
      aborted      = 1'b0;
    endfunction

    function void bump_count();
      if (nibble_count != COUNT_MAX) begin
        nibble_count++;
      end
    endfunction

    function void write_reg(cfg_reg_t idx, logic value);
      case (idx)
        REG_OUTPUT_FORMAT:       comp3_mode = value;
        REG_START_IN_LOW_NIBBLE: low_start = value;
        REG_PAD_ODD_LENGTH:      pad_odd = value;
        default: ;
      endcase
    endfunction

    function void note_char(in_item_t c);
      logic [7:0] offset;
      logic [3:0] digit;
      logic [3:0] low_fill;
      if (c.first_char) begin
        drop_string();
        if (comp3_mode) begin
          low_next = !c.odd_length;
        end else if (low_start) begin
          low_next = 1'b1;
        end else if (pad_odd && c.odd_length) begin
          low_next = 1'b1;
          bump_count();
        end
      end
      if (aborted) begin
        if (c.last_char) drop_string();
        return;
      end
      if (c.char_code < ASCII_ZERO || c.char_code > ASCII_NINE) begin
        expected_bytes.push_back('{packed_byte: 8'h00, nybble_count: nibble_count,
                                   error: 1'b1, string_end: 1'b1});
        aborted = 1'b1;
        if (c.last_char) drop_string();
        return;
      end
      offset = c.char_code - ASCII_ZERO;
      digit = offset[3:0];
      bump_count();
      if (!low_next) begin
        held_digit = digit;
        low_next = 1'b1;
        if (!c.last_char) return;
        // The string ends on a high nibble: zero fill, or the sign in COMP-3 mode.
        low_fill = !comp3_mode ? NIBBLE_ZERO :
                   (c.negative ? SIGN_NEGATIVE : SIGN_POSITIVE);
        expected_bytes.push_back('{packed_byte: {digit, low_fill}, nybble_count: nibble_count,
                                   error: 1'b0, string_end: 1'b1});
        drop_string();
        return;
      end
      expected_bytes.push_back('{packed_byte: {held_digit, digit}, nybble_count: nibble_count,
                                 error: 1'b0, string_end: c.last_char});
      held_digit = NIBBLE_ZERO;
      low_next = 1'b0;
      if (c.last_char) drop_string();
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      if (expected_bytes.size() == 0) begin
        $error("packed byte %h arrived with no result expected", got.packed_byte);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.packed_byte !== want.packed_byte) begin
        $error("packed_byte: expected %h, got %h", want.packed_byte, got.packed_byte);
        mismatches++;
      end
      if (got.nybble_count !== want.nybble_count) begin
        $error("nybble_count: expected %0d, got %0d", want.nybble_count, got.nybble_count);
        mismatches++;
      end
      if (got.error !== want.error) begin
        $error("error: expected %b, got %b", want.error, got.error);
        mismatches++;
      end
      if (got.string_end !== want.string_end) begin
        $error("string_end: expected %b, got %b", want.string_end, got.string_end);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic                   cfg_data;

  adpb_stream_if #(.payload_t(in_item_t))  char_ch ();
  adpb_stream_if #(.payload_t(out_item_t)) byte_ch ();

  packed_bcd_predictor bcd_model = new();

  // Idle rates in percent for the character sender and the byte receiver.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Each change of this counter asks the receiver for one long hold-off.
  int hold_trigger = 0;
  // Characters accepted so far, including those the block ignores.
  int chars_sent = 0;
  logic [7:0] text[$];

  ascii_digits_to_packed_bcd_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (char_ch),
    .out_ch    (byte_ch)
  );

  always #6 clk = ~clk;

  // Offers one character and waits for its handshake. Valid is only lowered
  // during an idle gap, so back-to-back items keep it high without a glitch.
  // Ready is sampled at the edge, before the block updates it, so the value
  // seen is the one that decided the handshake.
  task automatic send_char(input in_item_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      char_ch.valid <= 1'b0;
      @(posedge clk);
    end
    char_ch.valid <= 1'b1;
    char_ch.payload <= c;
    do @(posedge clk); while (!char_ch.ready);
    bcd_model.note_char(c);
    chars_sent++;
  endtask

  // Sends a whole string. The start and end marks can be left off to build
  // broken sequences; the parity and sign flags go on every character.
  task automatic send_string(input logic [7:0] chars[$], input logic odd, input logic neg,
                             input logic mark_first, input logic mark_end);
    in_item_t c;
    foreach (chars[i]) begin
      c.char_code  = chars[i];
      c.first_char = mark_first && (i == 0);
      c.last_char  = mark_end && (i == chars.size() - 1);
      c.odd_length = odd;
      c.negative   = neg;
      send_char(c);
    end
  endtask

  // Stops offering characters and waits until every predicted byte has been
  // checked. A character that makes no byte may still sit in the block's input
  // register, so the task waits on before treating the block as idle.
  task automatic drain_block();
    char_ch.valid <= 1'b0;
    while (bcd_model.expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three registers, one per cycle, and tells the predictor once
  // each write has landed. Setting bit 2 is the format, bit 1 the low-nibble
  // start and bit 0 the odd-length pad.
  task automatic write_config(input logic [2:0] setting);
    cfg_reg_t idx;
    logic     value;
    idx = idx.first();
    repeat (3) begin
      value = (idx == REG_OUTPUT_FORMAT)       ? setting[2] :
              (idx == REG_START_IN_LOW_NIBBLE) ? setting[1] : setting[0];
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data <= value;
      @(posedge clk);
      bcd_model.write_reg(idx, value);
      idx = idx.next();
    end
    cfg_write <= 1'b0;
  endtask

  // One random item group: mostly well-formed digit strings with random
  // content, some with a non-digit, a wrong parity flag or a missing mark,
  // and now and then a burst of raw noise on every field.
  task automatic send_random_string();
    logic [7:0] chars[$];
    logic [7:0] bad;
    in_item_t   c;
    int         len;
    int         kind;
    logic       odd;
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 6)) begin
        c.char_code  = 8'($urandom_range(255));
        c.first_char = ($urandom_range(99) < 30);
        c.last_char  = ($urandom_range(99) < 30);
        c.odd_length = 1'($urandom_range(1));
        c.negative   = 1'($urandom_range(1));
        send_char(c);
      end
      return;
    end
    len = $urandom_range(1, 8);
    repeat (len) chars.push_back(ASCII_ZERO + 8'($urandom_range(9)));
    if ($urandom_range(99) < 12) begin
      bad = 8'($urandom_range(255));
      if (bad >= ASCII_ZERO && bad <= ASCII_NINE) bad = bad ^ 8'h40;
      chars[$urandom_range(len - 1)] = bad;
    end
    odd = len[0];
    if ($urandom_range(99) < 8) odd = !odd;
    send_string(chars, odd, 1'($urandom_range(1)), $urandom_range(99) >= 4,
                $urandom_range(99) >= 4);
  endtask

  // A string longer than the nibble counter, so the count has to saturate.
  task automatic send_long_string();
    logic [7:0] chars[$];
    int         len;
    len = $urandom_range(256, 270);
    repeat (len) chars.push_back(ASCII_ZERO + 8'($urandom_range(9)));
    send_string(chars, len[0], 1'($urandom_range(1)), 1'b1, 1'b1);
  endtask

  // The receiver owns ready. It checks each accepted byte against the oldest
  // prediction, then picks ready for the next cycle: a long hold-off when
  // one has been asked for, otherwise at random by the current idle rate.
  initial begin : byte_sink
    int hold_left;
    int seen_trigger;
    hold_left = 0;
    seen_trigger = 0;
    byte_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (byte_ch.valid && byte_ch.ready) begin
        bcd_model.check_byte(byte_ch.payload);
      end
      if (hold_trigger != seen_trigger) begin
        seen_trigger = hold_trigger;
        hold_left = 40;
      end
      if (hold_left > 0) begin
        byte_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        byte_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Main sequence: reset, a directed pass over the special cases in each
  // mode, then twelve random groups, each under its own register setting.
  // The first eight groups walk every setting; the rest pick one at random.
  // Groups 0-3 idle the sender lightly and the receiver heavily, groups 4-7
  // swap the two, and groups 8-11 run with no idling at all.
  initial begin : stimulus
    int target;
    logic [2:0] setting;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_OUTPUT_FORMAT;
    cfg_data <= 1'b0;
    char_ch.valid <= 1'b0;
    char_ch.payload <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 10;
    recv_idle_pct = 80;

    // Plain mode with no padding: single digit with a zero low nibble, the
    // highest and lowest digits, non-digits at both ends of the code range
    // and just outside '0' and '9', and an aborted string whose tail is ignored.
    write_config(3'b000);
    text = '{"0"};
    send_string(text, 1'b1, 1'b0, 1'b1, 1'b1);
    text = '{"9", "0"};
    send_string(text, 1'b0, 1'b0, 1'b1, 1'b1);
    text = '{8'h00};
    send_string(text, 1'b1, 1'b0, 1'b1, 1'b1);
    text = '{"1", 8'hFF, "2"};
    send_string(text, 1'b1, 1'b0, 1'b1, 1'b1);
    text = '{"3", 8'h3A};
    send_string(text, 1'b0, 1'b0, 1'b1, 1'b1);
    text = '{8'h2F};
    send_string(text, 1'b1, 1'b0, 1'b1, 1'b1);
    // A string with no start mark right after a string end starts unpadded.
    text = '{"7", "8"};
    send_string(text, 1'b0, 1'b0, 1'b0, 1'b1);

    // COMP-3: odd length with a positive sign, even length padded with a
    // negative sign, and a parity flag that lies so the sign gets dropped.
    drain_block();
    write_config(3'b100);
    text = '{"1", "2", "3"};
    send_string(text, 1'b1, 1'b0, 1'b1, 1'b1);
    text = '{"4", "5"};
    send_string(text, 1'b0, 1'b1, 1'b1, 1'b1);
    text = '{"6", "7"};
    send_string(text, 1'b1, 1'b0, 1'b1, 1'b1);

    // Plain mode: low-nibble start wins over the odd-length pad, then the
    // pad on its own.
    drain_block();
    write_config(3'b011);
    text = '{"2", "3", "4"};
    send_string(text, 1'b1, 1'b0, 1'b1, 1'b1);
    drain_block();
    write_config(3'b001);
    text = '{"5", "6", "7"};
    send_string(text, 1'b1, 1'b0, 1'b1, 1'b1);

    for (int g = 0; g < 12; g++) begin
      drain_block();
      if (g == 4) begin
        send_idle_pct = 80;
        recv_idle_pct = 10;
      end else if (g == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      setting = (g < 8) ? 3'(g) : 3'($urandom_range(7));
      write_config(setting);
      // With no idling, hold the receiver off while characters keep coming
      // so that the block fills up and pushes back on its input.
      if (g == 8) hold_trigger <= hold_trigger + 1;
      if (g == 3 || g == 10) send_long_string();
      target = chars_sent + 50;
      while (chars_sent < target) send_random_string();
    end

    drain_block();
    repeat (6) @(posedge clk);
    if (bcd_model.mismatches == 0 && bcd_model.expected_bytes.size() == 0) begin
      $display("[ascii_digits_to_packed_bcd_unit] OK");
    end else begin
      $display("[ascii_digits_to_packed_bcd_unit] ERROR");
    end
    $finish;
  end

  // Guards against a hung handshake; far beyond the slowest correct run.
  initial begin : watchdog
    #6000000;
    $display("[ascii_digits_to_packed_bcd_unit] ERROR");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/adpb_pkg.sv
rtl/adpb_stream_if.sv
rtl/ascii_digits_to_packed_bcd_unit.sv
sim/tb.sv
